/* design/kpd_pkg.sv */
package kpd_pkg;

  // debounce length after reset
  localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

  // indices up to this value have a character
  localparam int unsigned LAST_MAPPED_KEY = 20;

  // one result beat as it leaves the core
  typedef struct packed {
    logic [3:0] column_drive;
    logic       key_valid;
    logic [4:0] key_index;
    logic [7:0] key_char;
  } kpd_result_t;

  // fixed key legend: matrix by row, then the standalone buttons
  function automatic logic [7:0] kpd_char(input logic [7:0] idx);
    logic [7:0] c;
    unique case (idx)
      8'd1:    c = "1";
      8'd2:    c = "2";
      8'd3:    c = "3";
      8'd4:    c = "A";
      8'd5:    c = "4";
      8'd6:    c = "5";
      8'd7:    c = "6";
      8'd8:    c = "B";
      8'd9:    c = "7";
      8'd10:   c = "8";
      8'd11:   c = "9";
      8'd12:   c = "C";
      8'd13:   c = "*";
      8'd14:   c = "0";
      8'd15:   c = "#";
      8'd16:   c = "D";
      8'd17:   c = "Q";
      8'd18:   c = "W";
      8'd19:   c = "E";
      8'd20:   c = "R";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/kpd_core.sv */
module kpd_core #(
  parameter int unsigned COLUMNS       = 4,
  parameter int unsigned ROWS          = 4,
  parameter int unsigned EXTRA_BUTTONS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [3:0]          row_lines_i,
  input  logic [3:0]          button_lines_i,
  input  logic [7:0]          debounce_i,
  output kpd_pkg::kpd_result_t result_o
);
  import kpd_pkg::*;

  localparam int unsigned MATRIX_KEYS = COLUMNS * ROWS;
  localparam int unsigned ROW_LIMIT   = (ROWS < 4) ? ROWS : 4;
  localparam int unsigned BTN_LIMIT   = (EXTRA_BUTTONS < 4) ? EXTRA_BUTTONS : 4;
  localparam int unsigned COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned IDX_W       = $clog2(MATRIX_KEYS + EXTRA_BUTTONS + 1);

  // phase codes
  localparam logic [1:0] PH_SCAN    = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;
  localparam logic [1:0] PH_POST    = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [7:0]       tick_q, tick_d;
  logic [IDX_W-1:0] held_q, held_d;

  logic [7:0]       tick_inc;
  logic [IDX_W-1:0] found;
  logic [IDX_W-1:0] report;
  logic [1:0]       row_sel;
  logic [1:0]       btn_sel;
  logic             is_button;
  logic             valid;
  logic [COL_W-1:0] col_next;
  logic [7:0]       report_wide;

  assign tick_inc  = tick_q + 8'd1;
  assign is_button = (int'(held_q) > MATRIX_KEYS);
  assign btn_sel   = 2'(int'(held_q) - MATRIX_KEYS - 1);
  assign col_next  = (int'(col_q) == COLUMNS - 1) ? '0 : COL_W'(int'(col_q) + 1);

  // row of the held matrix key, by comparing against each row's first key
  always_comb begin
    row_sel = 2'd0;
    for (int r = 1; r < ROWS; r++) begin
      if (int'(held_q) > r * COLUMNS) begin
        row_sel = 2'(r);
      end
    end
  end

  // press search: buttons first, highest bit wins, then highest row
  always_comb begin
    found = '0;
    for (int i = 0; i < BTN_LIMIT; i++) begin
      if (!button_lines_i[i]) begin
        found = IDX_W'(MATRIX_KEYS + 1 + i);
      end
    end
    if (found == '0) begin
      for (int i = 0; i < ROW_LIMIT; i++) begin
        if (!row_lines_i[i]) begin
          found = IDX_W'(i * COLUMNS + int'(col_q) + 1);
        end
      end
    end
  end

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    tick_d  = tick_q;
    held_d  = held_q;
    valid   = 1'b0;
    report  = '0;
    unique case (phase_q)
      PH_PRESS: begin
        tick_d = tick_inc;
        if (tick_inc >= debounce_i) begin
          phase_d = PH_RELEASE;
          tick_d  = 8'd0;
        end
      end
      PH_RELEASE: begin
        if (is_button) begin
          if (button_lines_i[btn_sel]) begin
            valid  = 1'b1;
            report = held_q;
          end
        end else if (row_lines_i[row_sel]) begin
          phase_d = PH_POST;
          tick_d  = 8'd0;
        end
      end
      PH_POST: begin
        tick_d = tick_inc;
        if (tick_inc >= debounce_i) begin
          valid  = 1'b1;
          report = held_q;
        end
      end
      default: begin
        if (found != '0) begin
          held_d  = found;
          phase_d = PH_PRESS;
          tick_d  = 8'd0;
        end else begin
          col_d = col_next;
        end
      end
    endcase
    // report closes the key and moves the scan on
    if (valid) begin
      held_d  = '0;
      phase_d = PH_SCAN;
      tick_d  = 8'd0;
      col_d   = col_next;
    end
  end

  // result beat
  assign report_wide = 8'(report);

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      result_o.column_drive[b] = (int'(col_d) != b);
    end
    result_o.key_valid = valid;
    result_o.key_index = report_wide[4:0];
    result_o.key_char  = (int'(report) <= LAST_MAPPED_KEY) ? kpd_char(report_wide) : 8'h00;
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      col_q   <= '0;
      tick_q  <= 8'd0;
      held_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      tick_q  <= tick_d;
      held_q  <= held_d;
    end
  end

endmodule

/* design/matrix_keypad_scanner_debounce.sv */
// the result beat is registered at the edge that accepts the input beat
// throughput: one beat per cycle; the input stalls only while a result waits
//   in the output register and the output side stalls
// reset: asynchronous active low; column counter at zero, scanning, no key held,
//   debounce length 20, output register empty
module matrix_keypad_scanner_debounce #(
  parameter int unsigned COLUMNS       = 4,
  parameter int unsigned ROWS          = 4,
  parameter int unsigned EXTRA_BUTTONS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       debounce_ticks_we_i,
  input  logic [7:0] debounce_ticks_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] row_lines_i,
  input  logic [3:0] button_lines_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] column_drive_o,
  output logic       key_valid_o,
  output logic [4:0] key_index_o,
  output logic [7:0] key_char_o
);
  import kpd_pkg::*;

  logic [7:0]  debounce_ticks_q;
  logic        accept;
  logic        out_valid_q;
  kpd_result_t result;
  kpd_result_t result_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_RESET;
    end else if (debounce_ticks_we_i) begin
      debounce_ticks_q <= debounce_ticks_i;
    end
  end

  // zero acts like one, which the compare already does
  kpd_core #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .EXTRA_BUTTONS(EXTRA_BUTTONS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .row_lines_i   (row_lines_i),
    .button_lines_i(button_lines_i),
    .debounce_i    (debounce_ticks_q),
    .result_o      (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_drive_o = result_q.column_drive;
  assign key_valid_o    = result_q.key_valid;
  assign key_index_o    = result_q.key_index;
  assign key_char_o     = result_q.key_char;

endmodule
